FILE: rtl/ptl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared types, widths and constants of the polar tile locator.
// ----------------------------------------------------------------------------
package ptl_pkg;

  localparam int MAX_RINGS    = 5;
  localparam int COORD_BITS   = 18;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 30;

  localparam int CW         = COORD_BITS + 16;  // cordic datapath word
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int RAD_BITS   = 17;
  localparam int GAP_BITS   = 16;
  localparam int RC_BITS    = 3;
  localparam int CNT_BITS   = 8;
  localparam int CNTS_BITS  = 40;
  localparam int NUM_CNT    = CNTS_BITS / CNT_BITS;
  localparam int TILE_BITS  = 11;
  localparam int CFG_DATA_BITS = 40;
  localparam int CFG_IDX_BITS  = 3;
  localparam int TPR_BITS   = 30;
  localparam int GN_BITS    = GAP_BITS + RC_BITS;
  localparam int NUM_BITS   = GN_BITS + TPR_BITS;
  localparam int EDGE_BITS  = 24;
  localparam int TURN_BITS  = 32;

  localparam logic [TPR_BITS-1:0] TURN_PER_RAD = 30'd683565275;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INNER  = 3'd0,
    REG_OUTER  = 3'd1,
    REG_RINGS  = 3'd2,
    REG_GAP    = 3'd3,
    REG_COUNTS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [RAD_BITS-1:0]  inner;
    logic [RAD_BITS-1:0]  outer;
    logic [RC_BITS-1:0]   rings;
    logic [GAP_BITS-1:0]  gap;
    logic [CNTS_BITS-1:0] counts;
  } cfg_t;

  typedef struct packed {
    logic                  rej;
    logic [ANGLE_BITS-1:0] phi;
    logic [CNT_BITS-1:0]   cnt;
    logic [TILE_BITS-1:0]  base;
  } tag_t;

  typedef struct packed {
    logic [NUM_BITS-1:0]  num;
    logic [EDGE_BITS-1:0] edge_len;
    tag_t                 tag;
  } ring_out_t;

  typedef struct packed {
    logic [TURN_BITS-1:0] half;
    tag_t                 tag;
  } div_out_t;

  function automatic logic [TURN_BITS-1:0] atan_turn(input int i);
    logic [TURN_BITS-1:0] a;
    case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/polar_tile_locator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_tile_locator
// Maps a hit position to its tile number on a ring-segmented annular plane.
//
//   channel  direction  ports                                handshake
//   in       input      in_hit_x, in_hit_y                   in_valid / in_stall
//   out      output     out_tile_number, out_in_tile         out_valid / out_stall
//   cfg      input      cfg_index, cfg_wdata                 cfg_we
//
// One hit transfers per cycle unless out_stall holds the pipeline; a hit
// passes through radius square root and angle CORDIC, ring selection, the
// gap divider, and the angular test and the output register, in that order.
// Reset is synchronous, active low; it clears all valid bits and loads the
// register defaults. Each stage holds only while the one after it is full and
// held, so out_stall backs up through the pipeline bubble by bubble.
// ----------------------------------------------------------------------------
module polar_tile_locator (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [ptl_pkg::COORD_BITS-1:0]    in_hit_x,
  input  logic signed [ptl_pkg::COORD_BITS-1:0]    in_hit_y,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [ptl_pkg::TILE_BITS-1:0]            out_tile_number,
  output logic                                     out_in_tile,
  input  logic                                     cfg_we,
  input  logic [ptl_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [ptl_pkg::CFG_DATA_BITS-1:0]        cfg_wdata
);

  ptl_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inner  <= '0;
      cfg_r.outer  <= '0;
      cfg_r.rings  <= ptl_pkg::RC_BITS'(1);
      cfg_r.gap    <= '0;
      cfg_r.counts <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptl_pkg::REG_INNER:  cfg_r.inner  <= cfg_wdata[ptl_pkg::RAD_BITS-1:0];
        ptl_pkg::REG_OUTER:  cfg_r.outer  <= cfg_wdata[ptl_pkg::RAD_BITS-1:0];
        ptl_pkg::REG_RINGS:  cfg_r.rings  <= cfg_wdata[ptl_pkg::RC_BITS-1:0];
        ptl_pkg::REG_GAP:    cfg_r.gap    <= cfg_wdata[ptl_pkg::GAP_BITS-1:0];
        ptl_pkg::REG_COUNTS: cfg_r.counts <= cfg_wdata[ptl_pkg::CNTS_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic                           pol_valid, pol_ready;
  logic [ptl_pkg::COORD_BITS-1:0] pol_r;
  logic [ptl_pkg::TURN_BITS-1:0]  pol_z;
  logic                           ring_valid, ring_ready;
  ptl_pkg::ring_out_t             ring_data;
  logic                           div_valid, div_ready;
  ptl_pkg::div_out_t              div_data;
  logic                           in_ready;

  ptl_polar u_polar (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_hit_x),
    .in_y      (in_hit_y),
    .out_valid (pol_valid),
    .out_ready (pol_ready),
    .out_r     (pol_r),
    .out_z     (pol_z)
  );

  ptl_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (pol_valid),
    .in_ready  (pol_ready),
    .in_r      (pol_r),
    .in_z      (pol_z),
    .out_valid (ring_valid),
    .out_ready (ring_ready),
    .out_data  (ring_data)
  );

  ptl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ring_valid),
    .in_ready  (ring_ready),
    .in_data   (ring_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  ptl_tile u_tile (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_tile  (out_tile_number)
  );

  assign in_stall    = !in_ready;
  assign out_in_tile = (out_tile_number != '0);

endmodule

FILE: rtl/ptl_polar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_polar
// Squared radius, then radius by bit-pair square root and angle by vectoring
// CORDIC, up to two steps of each per pipeline stage.
// ----------------------------------------------------------------------------
module ptl_polar (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ptl_pkg::COORD_BITS-1:0] in_x,
  input  logic signed [ptl_pkg::COORD_BITS-1:0] in_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ptl_pkg::COORD_BITS-1:0]        out_r,
  output logic [ptl_pkg::TURN_BITS-1:0]         out_z
);

  localparam int CW  = ptl_pkg::CW;
  localparam int CB  = ptl_pkg::COORD_BITS;
  localparam int SQB = ptl_pkg::SQ_BITS;
  localparam int RW  = CB + 4;
  localparam int MX  = (ptl_pkg::CORDIC_STEPS > CB) ? ptl_pkg::CORDIC_STEPS : CB;
  localparam int NS  = (MX + 1) / 2;

  typedef struct packed {
    logic signed [CW-1:0]          cx;
    logic signed [CW-1:0]          cy;
    logic [ptl_pkg::TURN_BITS-1:0] z;
    logic [SQB-1:0]                sq;
    logic [RW-1:0]                 rem;
    logic [CB-1:0]                 root;
  } pol_t;

  function automatic pol_t cordic_step(input pol_t t, input int i);
    pol_t o;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    o  = t;
    dx = t.cy >>> i;
    dy = t.cx >>> i;
    if (t.cy > 0) begin
      o.cx = t.cx + dx;
      o.cy = t.cy - dy;
      o.z  = t.z + ptl_pkg::atan_turn(i);
    end else if (t.cy < 0) begin
      o.cx = t.cx - dx;
      o.cy = t.cy + dy;
      o.z  = t.z - ptl_pkg::atan_turn(i);
    end
    return o;
  endfunction

  function automatic pol_t sqrt_step(input pol_t t);
    pol_t o;
    logic [RW-1:0] rn;
    logic [RW-1:0] trial;
    o     = t;
    rn    = {t.rem[RW-3:0], t.sq[SQB-1 -: 2]};
    trial = RW'({t.root, 2'b01});
    o.sq  = {t.sq[SQB-3:0], 2'b00};
    if (rn >= trial) begin
      o.rem  = rn - trial;
      o.root = {t.root[CB-2:0], 1'b1};
    end else begin
      o.rem  = rn;
      o.root = {t.root[CB-2:0], 1'b0};
    end
    return o;
  endfunction

  pol_t        st_r   [0:NS];
  pol_t        st_nxt [0:NS];
  logic [NS:0] v_r;
  logic [NS:0] en;

  always_comb begin
    logic signed [CW-1:0]  ax;
    logic signed [CW-1:0]  ay;
    logic signed [SQB-1:0] xx;
    logic signed [SQB-1:0] yy;
    ax = CW'(in_x);
    ay = CW'(in_y);
    xx = in_x * in_x;
    yy = in_y * in_y;
    st_nxt[0].z = '0;
    if (in_x < 0) begin
      ax = -ax;
      ay = -ay;
      st_nxt[0].z = 32'h8000_0000;
    end
    st_nxt[0].cx   = ax <<< 12;
    st_nxt[0].cy   = ay <<< 12;
    st_nxt[0].sq   = $unsigned(xx) + $unsigned(yy);
    st_nxt[0].rem  = '0;
    st_nxt[0].root = '0;
  end

  for (genvar s = 1; s <= NS; s++) begin : g_stage
    always_comb begin
      pol_t t;
      t = st_r[s-1];
      for (int j = 0; j < 2; j++) begin
        if (2 * (s - 1) + j < ptl_pkg::CORDIC_STEPS) t = cordic_step(t, 2 * (s - 1) + j);
        if (2 * (s - 1) + j < CB) t = sqrt_step(t);
      end
      st_nxt[s] = t;
    end
  end

  always_comb begin
    en[NS] = !v_r[NS] || out_ready;
    for (int i = NS - 1; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i <= NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= NS; i++) begin
      if (en[i]) st_r[i] <= st_nxt[i];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS];
  assign out_r     = st_r[NS].root;
  assign out_z     = st_r[NS].z;

endmodule

FILE: rtl/ptl_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_ring
// Ring selection, radial gap test, tile outer edge, angular gap numerator,
// tile count and ring base, over three stages.
// ----------------------------------------------------------------------------
module ptl_ring (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ptl_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ptl_pkg::COORD_BITS-1:0] in_r,
  input  logic [ptl_pkg::TURN_BITS-1:0]  in_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ptl_pkg::ring_out_t             out_data
);

  localparam int CB  = ptl_pkg::COORD_BITS;
  localparam int DNB = CB + ptl_pkg::RC_BITS;
  localparam int JWB = ptl_pkg::RAD_BITS + ptl_pkg::RC_BITS;
  localparam int SW  = ((DNB > JWB) ? DNB : JWB) + 4;

  typedef struct packed {
    logic                           rej;
    logic [DNB-1:0]                 dn;
    logic [ptl_pkg::GN_BITS-1:0]    gn;
    logic [ptl_pkg::ANGLE_BITS-1:0] phi;
  } sa_t;

  typedef struct packed {
    logic                           rej;
    logic [ptl_pkg::RC_BITS-1:0]    nr;
    logic [DNB-1:0]                 dn;
    logic [ptl_pkg::GN_BITS-1:0]    gn;
    logic [ptl_pkg::NUM_BITS-1:0]   num;
    logic [ptl_pkg::ANGLE_BITS-1:0] phi;
  } sb_t;

  sa_t  a_r, a_nxt;
  sb_t  b_r, b_nxt;
  ptl_pkg::ring_out_t c_r, c_nxt;
  logic [2:0] v_r;
  logic [2:0] en;

  logic [ptl_pkg::RAD_BITS-1:0] w;
  assign w = cfg.outer - cfg.inner;

  always_comb begin
    logic below;
    logic bad;
    logic [CB-1:0] d;
    below = in_r < CB'(cfg.inner);
    bad   = (cfg.rings == '0) || (32'(cfg.rings) > ptl_pkg::MAX_RINGS) ||
            (cfg.outer <= cfg.inner);
    d         = in_r - CB'(cfg.inner);
    a_nxt.rej = below || bad;
    a_nxt.dn  = DNB'(d) * DNB'(cfg.rings);
    a_nxt.gn  = ptl_pkg::GN_BITS'(cfg.gap) * ptl_pkg::GN_BITS'(cfg.rings);
    a_nxt.phi = in_z[ptl_pkg::TURN_BITS-1 -: ptl_pkg::ANGLE_BITS];
  end

  always_comb begin
    logic [JWB-1:0] nw;
    logic [ptl_pkg::RC_BITS-1:0] cnt;
    cnt = '0;
    for (int j = 1; j < ptl_pkg::MAX_RINGS; j++) begin
      if (DNB'(JWB'(w) * JWB'(j)) <= a_r.dn) cnt = cnt + 1'b1;
    end
    nw        = JWB'(w) * JWB'(cfg.rings);
    b_nxt.rej = a_r.rej || (a_r.dn >= DNB'(nw));
    b_nxt.nr  = cnt;
    b_nxt.dn  = a_r.dn;
    b_nxt.gn  = a_r.gn;
    b_nxt.num = ptl_pkg::NUM_BITS'(a_r.gn) * ptl_pkg::NUM_BITS'(ptl_pkg::TURN_PER_RAD);
    b_nxt.phi = a_r.phi;
  end

  always_comb begin
    logic [JWB-1:0] nrw;
    logic [JWB-1:0] rin_n;
    logic signed [SW-1:0] span;
    logic signed [SW-1:0] lo;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] tdn;
    logic signed [SW-1:0] edge_s;
    logic [ptl_pkg::CNT_BITS-1:0]  cnt;
    logic [ptl_pkg::TILE_BITS-1:0] base;
    nrw    = JWB'(w) * JWB'(b_r.nr);
    rin_n  = JWB'(cfg.inner) * JWB'(cfg.rings);
    span   = SW'(nrw) + SW'(w);
    lo     = (SW'(nrw) <<< 1) + SW'(b_r.gn);
    hi     = (span <<< 1) - SW'(b_r.gn);
    tdn    = SW'(b_r.dn) <<< 1;
    edge_s = (SW'(rin_n) <<< 1) + (span <<< 1) - SW'(b_r.gn);
    cnt    = '0;
    base   = '0;
    for (int j = 0; j < ptl_pkg::NUM_CNT; j++) begin
      if (32'(b_r.nr) == j) cnt = cfg.counts[j*ptl_pkg::CNT_BITS +: ptl_pkg::CNT_BITS];
      if (j < 32'(b_r.nr)) begin
        base = base + ptl_pkg::TILE_BITS'(cfg.counts[j*ptl_pkg::CNT_BITS +: ptl_pkg::CNT_BITS]);
      end
    end
    c_nxt.num      = b_r.num;
    c_nxt.edge_len = edge_s[ptl_pkg::EDGE_BITS-1:0];
    c_nxt.tag.rej  = b_r.rej || (tdn < lo) || (tdn > hi) || (cnt == '0) || (edge_s <= 0);
    c_nxt.tag.phi  = b_r.phi;
    c_nxt.tag.cnt  = cnt;
    c_nxt.tag.base = base;
  end

  always_comb begin
    en[2] = !v_r[2] || out_ready;
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) a_r <= a_nxt;
    if (en[1]) b_r <= b_nxt;
    if (en[2]) c_r <= c_nxt;
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[2];
  assign out_data  = c_r;

endmodule

FILE: rtl/ptl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_div
// Pipelined restoring divider for the half angular gap, two quotient bits
// per stage, with a full-turn overflow check up front.
// ----------------------------------------------------------------------------
module ptl_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptl_pkg::ring_out_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ptl_pkg::div_out_t   out_data
);

  localparam int TB = ptl_pkg::TURN_BITS;
  localparam int EB = ptl_pkg::EDGE_BITS;
  localparam int NS = TB / 2;

  typedef struct packed {
    logic [EB-1:0] edge_len;
    logic [EB-1:0] rem;
    logic [TB-1:0] lowb;
    logic [TB-1:0] q;
    ptl_pkg::tag_t tag;
  } dv_t;

  function automatic dv_t div_step(input dv_t t);
    dv_t o;
    logic [EB:0] tr;
    o      = t;
    tr     = {t.rem, t.lowb[TB-1]};
    o.lowb = {t.lowb[TB-2:0], 1'b0};
    if (tr >= {1'b0, t.edge_len}) begin
      o.rem = EB'(tr - {1'b0, t.edge_len});
      o.q   = {t.q[TB-2:0], 1'b1};
    end else begin
      o.rem = tr[EB-1:0];
      o.q   = {t.q[TB-2:0], 1'b0};
    end
    return o;
  endfunction

  dv_t         st_r   [0:NS];
  dv_t         st_nxt [0:NS];
  logic [NS:0] v_r;
  logic [NS:0] en;

  always_comb begin
    logic [EB-1:0] hi_part;
    hi_part = EB'(in_data.num[ptl_pkg::NUM_BITS-1:TB]);
    st_nxt[0].edge_len = in_data.edge_len;
    st_nxt[0].rem      = hi_part;
    st_nxt[0].lowb     = in_data.num[TB-1:0];
    st_nxt[0].q        = '0;
    st_nxt[0].tag      = in_data.tag;
    st_nxt[0].tag.rej  = in_data.tag.rej || (hi_part >= in_data.edge_len);
  end

  for (genvar s = 1; s <= NS; s++) begin : g_stage
    always_comb begin
      st_nxt[s] = div_step(div_step(st_r[s-1]));
    end
  end

  always_comb begin
    en[NS] = !v_r[NS] || out_ready;
    for (int i = NS - 1; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i <= NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= NS; i++) begin
      if (en[i]) st_r[i] <= st_nxt[i];
    end
  end

  assign in_ready      = en[0];
  assign out_valid     = v_r[NS];
  assign out_data.half = st_r[NS].q;
  assign out_data.tag  = st_r[NS].tag;

endmodule

FILE: rtl/ptl_tile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_tile
// Angular tile index, angular gap test and final tile number; the last
// stage is the output register.
// ----------------------------------------------------------------------------
module ptl_tile (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ptl_pkg::div_out_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptl_pkg::TILE_BITS-1:0] out_tile
);

  localparam int AB = ptl_pkg::ANGLE_BITS;
  localparam int CN = ptl_pkg::CNT_BITS;
  localparam int TB = ptl_pkg::TURN_BITS;
  localparam int PB = AB + CN;
  localparam int HB = TB + CN;
  localparam int XB = HB + 1;

  typedef struct packed {
    logic                          rej;
    logic [PB-1:0]                 pn;
    logic [HB-1:0]                 nh;
    logic [ptl_pkg::TILE_BITS-1:0] base;
  } ta_t;

  ta_t  a_r, a_nxt;
  logic [ptl_pkg::TILE_BITS-1:0] t_r, t_nxt;
  logic [1:0] v_r;
  logic [1:0] en;

  always_comb begin
    a_nxt.rej  = in_data.tag.rej;
    a_nxt.pn   = PB'(in_data.tag.phi) * PB'(in_data.tag.cnt);
    a_nxt.nh   = HB'(in_data.half) * HB'(in_data.tag.cnt);
    a_nxt.base = in_data.tag.base;
  end

  always_comb begin
    logic [XB-1:0] fr;
    logic [CN-1:0] k;
    logic ok;
    fr = XB'({a_r.pn[AB-1:0], {(TB-AB){1'b0}}});
    k  = a_r.pn[PB-1:AB];
    ok = (fr >= XB'(a_r.nh)) && ((fr + XB'(a_r.nh)) <= (XB'(1) << TB));
    if (ok && !a_r.rej) t_nxt = a_r.base + ptl_pkg::TILE_BITS'(k) + 1'b1;
    else t_nxt = '0;
  end

  always_comb begin
    en[1] = !v_r[1] || out_ready;
    en[0] = !v_r[0] || en[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) a_r <= a_nxt;
    if (en[1]) t_r <= t_nxt;
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[1];
  assign out_tile  = t_r;

endmodule

FILE: bench/ptl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_checker
// Watches the hit, tile and register ports of the polar tile locator. It
// keeps its own copy of the registers, predicts the tile for each hit
// transfer and compares every tile transfer, in order, with the prediction.
// ----------------------------------------------------------------------------
module ptl_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [ptl_pkg::COORD_BITS-1:0] in_hit_x,
  input  logic signed [ptl_pkg::COORD_BITS-1:0] in_hit_y,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic [ptl_pkg::TILE_BITS-1:0]         out_tile_number,
  input  logic                                  out_in_tile,
  input  logic                                  cfg_we,
  input  logic [ptl_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [ptl_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  output int                                    fail_count,
  output int                                    tiles_pending
);

  typedef struct packed {
    logic [ptl_pkg::TILE_BITS-1:0] tile;
    logic                          hit;
  } tile_res_t;

  ptl_pkg::cfg_t regs;
  tile_res_t     tiles_due[$];

  function automatic logic [ptl_pkg::TILE_BITS-1:0] locate_tile(ptl_pkg::cfg_t c,
      logic signed [ptl_pkg::COORD_BITS-1:0] hx, logic signed [ptl_pkg::COORD_BITS-1:0] hy);
    longint nrg, rin, span_w, g, r, d, ring_i, lo, hi, edge_len, tile_n;
    longint half, p, v, k, x, y, dx, dy;
    longint unsigned sq, res, bitv;
    logic [31:0] z, phi, base;
    bit stop;
    nrg = longint'(c.rings);
    rin = longint'(c.inner);
    if (nrg == 0 || nrg > ptl_pkg::MAX_RINGS) return '0;
    if (c.outer <= c.inner) return '0;
    span_w = longint'(c.outer) - rin;
    g = longint'(c.gap);
    x = longint'(hx);
    y = longint'(hy);
    sq = x * x + y * y;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > sq) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (sq >= res + bitv) begin
        sq = sq - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    r = longint'(res);
    if (r < rin) return '0;
    d = r - rin;
    ring_i = d * nrg / span_w;
    if (ring_i >= nrg) return '0;
    lo = 2 * ring_i * span_w + nrg * g;
    hi = 2 * (ring_i + 1) * span_w - nrg * g;
    if (2 * nrg * d < lo || 2 * nrg * d > hi) return '0;
    tile_n = longint'((c.counts >> (8 * ring_i)) & 40'hFF);
    if (tile_n == 0) return '0;
    edge_len = 2 * nrg * rin + 2 * (ring_i + 1) * span_w - nrg * g;
    if (edge_len <= 0) return '0;
    half = (g * nrg * longint'(ptl_pkg::TURN_PER_RAD)) / edge_len;
    if (half >= (64'sd1 <<< 32)) return '0;
    // angle by CORDIC, 2^-32 turn
    z = 32'h0;
    if (!(x == 0 && y == 0)) begin
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h80000000;
      end
      x = x * 4096;
      y = y * 4096;
      stop = 0;
      for (int i = 0; i < ptl_pkg::CORDIC_STEPS && !stop; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx; y = y - dy; z = z + ptl_pkg::atan_turn(i);
        end else if (y < 0) begin
          x = x - dx; y = y + dy; z = z - ptl_pkg::atan_turn(i);
        end else begin
          stop = 1;
        end
      end
    end
    phi = z >> (32 - ptl_pkg::ANGLE_BITS);
    p = longint'(phi) << (32 - ptl_pkg::ANGLE_BITS);
    v = p * tile_n;
    k = v >>> 32;
    lo = k * (64'sd1 <<< 32) + tile_n * half;
    hi = (k + 1) * (64'sd1 <<< 32) - tile_n * half;
    if (v < lo || v > hi) return '0;
    base = 32'h0;
    for (longint i = 0; i < ring_i; i++) begin
      base = base + 32'((c.counts >> (8 * i)) & 40'hFF);
    end
    base = base + 32'(k) + 32'd1;
    return base[ptl_pkg::TILE_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    tile_res_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      regs <= '{inner: '0, outer: '0, rings: 3'd1, gap: '0, counts: '0};
      tiles_due.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (ptl_pkg::cfg_reg_t'(cfg_index))
          ptl_pkg::REG_INNER:  regs.inner  <= cfg_wdata[ptl_pkg::RAD_BITS-1:0];
          ptl_pkg::REG_OUTER:  regs.outer  <= cfg_wdata[ptl_pkg::RAD_BITS-1:0];
          ptl_pkg::REG_RINGS:  regs.rings  <= cfg_wdata[ptl_pkg::RC_BITS-1:0];
          ptl_pkg::REG_GAP:    regs.gap    <= cfg_wdata[ptl_pkg::GAP_BITS-1:0];
          ptl_pkg::REG_COUNTS: regs.counts <= cfg_wdata[ptl_pkg::CNTS_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want.tile = locate_tile(regs, in_hit_x, in_hit_y);
        want.hit  = want.tile != 0;
        tiles_due = {tiles_due, want};
      end
      if (out_valid && !out_stall) begin
        if (tiles_due.size() == 0) begin
          $error("tile transfer with no hit outstanding");
          errs++;
        end else begin
          want = tiles_due.pop_front();
          if (out_tile_number !== want.tile) begin
            $error("tile_number: expected %0d, actual %0d", want.tile, out_tile_number);
            errs++;
          end
          if (out_in_tile !== want.hit) begin
            $error("in_tile: expected %0d, actual %0d", want.hit, out_in_tile);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    tiles_pending <= tiles_due.size();
  end

endmodule

FILE: bench/polar_tile_locator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_tile_locator_test
// Drives register settings and hit streams into the polar tile locator,
// with random idle cycles on both channels in all but the last phases; the
// checker predicts and compares each tile transfer.
// ----------------------------------------------------------------------------
module polar_tile_locator_test;

  localparam int CB  = ptl_pkg::COORD_BITS;
  localparam int DW  = ptl_pkg::CFG_DATA_BITS;
  localparam int CNB = ptl_pkg::CNTS_BITS;
  localparam int LATENCY = 38;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [CB-1:0] in_hit_x = '0;
  logic signed [CB-1:0] in_hit_y = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [ptl_pkg::TILE_BITS-1:0] out_tile_number;
  logic out_in_tile;
  logic cfg_we = 0;
  logic [ptl_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_wdata = '0;

  int fail_count, tiles_pending;
  int tx_idle_pct = 21, rx_idle_pct = 49;
  int quiet_cycles = 0;
  logic [ptl_pkg::RAD_BITS-1:0] cur_outer = '0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  polar_tile_locator dut (.*);

  ptl_checker chk (.*);

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("polar_tile_locator verification failed");
      $finish;
    end
  end

  task automatic write_reg(ptl_pkg::cfg_reg_t idx, logic [DW-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == ptl_pkg::REG_OUTER) cur_outer = val[ptl_pkg::RAD_BITS-1:0];
  endtask

  task automatic setup(int inner, int outer, int rings, int gap,
                       logic [CNB-1:0] counts);
    write_reg(ptl_pkg::REG_INNER, DW'(inner));
    write_reg(ptl_pkg::REG_OUTER, DW'(outer));
    write_reg(ptl_pkg::REG_RINGS, DW'(rings));
    write_reg(ptl_pkg::REG_GAP, DW'(gap));
    write_reg(ptl_pkg::REG_COUNTS, counts);
    cfg_we <= 0;
  endtask

  task automatic send_hit(logic signed [CB-1:0] hx,
                          logic signed [CB-1:0] hy);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_hit_x <= hx;
    in_hit_y <= hy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(int count);
    int span;
    for (int i = 0; i < count; i++) begin
      span = (cur_outer > 131071) ? 131071 : int'(cur_outer);
      if ($urandom_range(0, 3) == 0 || span < 2)
        send_hit(CB'($urandom()), CB'($urandom()));
      else
        send_hit(CB'($urandom_range(0, 2 * span) - span),
                 CB'($urandom_range(0, 2 * span) - span));
    end
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (tiles_pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_random(20);
    drain;

    setup(10000, 100000, 5, 300, 40'h30_24_1C_10_08);
    send_hit(0, 0);
    send_hit(131071, 131071);
    send_hit(-131072, -131072);
    send_hit(131071, -131072);
    send_hit(-131072, 131071);
    send_hit(50000, 0);
    send_hit(0, 50000);
    send_hit(-50000, 0);
    send_hit(0, -50000);
    send_hit(9999, 0);
    send_hit(10000, 0);
    send_hit(28000, 0);
    send_hit(99999, 0);
    send_hit(100000, 0);
    send_hit(30000, 30000);
    send_hit(-1, -1);
    send_hit(1, 0);
    send_random(60);
    drain;

    setup(0, 131071, 1, 0, 40'hFF);
    send_random(50);
    drain;

    tx_idle_pct = 49; rx_idle_pct = 21;
    setup(20000, 120000, 4, 65535, 40'hFF_00_40_20);
    send_random(30);
    drain;
    setup(0, 131071, 5, 2000, 40'hFF_FF_00_FF_FF);
    send_random(50);
    drain;
    setup(50000, 50000, 2, 0, 40'h0101);
    send_random(15);
    drain;
    write_reg(ptl_pkg::REG_RINGS, DW'(0));
    cfg_we <= 0;
    send_random(15);
    drain;
    write_reg(ptl_pkg::REG_RINGS, DW'(7));
    cfg_we <= 0;
    send_random(15);
    drain;

    tx_idle_pct = 0; rx_idle_pct = 0;
    for (int ph = 0; ph < 3; ph++) begin
      int inner_r;
      inner_r = int'($urandom_range(0, 60000));
      setup(inner_r, int'($urandom_range(inner_r + 1, 131071)), int'($urandom_range(1, 5)),
            int'($urandom_range(0, 1500)), CNB'({$urandom(), $urandom()}));
      send_random(45);
      drain;
    end

    if (fail_count == 0)
      $display("polar_tile_locator verification clean");
    else
      $display("polar_tile_locator verification failed");
    $finish;
  end

endmodule
